// ===== src/phase_shift_ratio_decode_macros.svh =====
// Assertion macros of the phase ratio decoder, used by psr_scale.
`ifndef PHASE_SHIFT_RATIO_DECODE_MACROS_SVH
`define PHASE_SHIFT_RATIO_DECODE_MACROS_SVH

// Check that cond implies prop in the same cycle.
`define PSR_ASSERT_SAME(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);

// Check that cond implies prop in the next cycle.
`define PSR_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== src/psr_pkg.sv =====
// Shared types, constants and register codes of the phase ratio decoder.
package psr_pkg;

	localparam int SAMPLE_BITS_DEF   = 16;
	localparam int FRACTION_BITS_DEF = 16;

	localparam int SAMPLE_W = 16;
	localparam int PHASE_W  = 28;
	localparam int GAIN_W   = 32;
	localparam int MASK_W   = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [GAIN_W-1:0] GAIN_RESET      = 32'd170891319;
	localparam logic [MASK_W-1:0] MASK_LOW_RESET  = 16'd15;
	localparam logic [MASK_W-1:0] MASK_HIGH_RESET = 16'd254;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PHASE_GAIN = 2'd0,
		CFG_MASK_LOW   = 2'd1,
		CFG_MASK_HIGH  = 2'd2
	} cfg_idx_t;

	// Region base in units of two: ratio base is 2 * code.
	typedef enum logic [1:0] {
		BASE_0 = 2'd0,
		BASE_2 = 2'd1,
		BASE_4 = 2'd2,
		BASE_6 = 2'd3
	} base_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample_a;
		logic [SAMPLE_W-1:0] sample_b;
		logic [SAMPLE_W-1:0] sample_c;
	} pixel_t;

	typedef struct packed {
		logic [PHASE_W-1:0]  phase_value;
		logic [SAMPLE_W-1:0] brightness;
		logic                pixel_valid;
		logic                flat_pixel;
	} result_t;

	// Side information that rides along with the divider.
	// whole marks a fraction of exactly one (numerator equal to a nonzero divisor).
	typedef struct packed {
		base_t               base;
		logic                subtract;
		logic                flat;
		logic                whole;
		logic [SAMPLE_W-1:0] bright;
	} side_t;

	typedef struct packed {
		logic [GAIN_W-1:0] phase_gain;
		logic [MASK_W-1:0] mask_low;
		logic [MASK_W-1:0] mask_high;
	} cfg_t;

endpackage

// ===== src/phase_shift_ratio_decode.sv =====
// Top level of the three-step phase shift intensity-ratio decoder.
//
// Usage:
//   Present one pixel (three samples) on pixel and raise start; the
//   transaction is taken at a rising edge with start high and busy low.
//   busy stays low, so a new pixel may enter on every clock.
//   Each pixel gives exactly one result on result, marked by a one-cycle
//   done strobe. The pipeline has one sort stage, one divider stage per
//   quotient bit, then ratio, gain multiply and saturate/mask stages.
//   Throughput is one pixel per clock.
//   Results come out in input order; the receiver must take each result in
//   the cycle it is shown, it cannot stall the pipeline.
//   Configuration writes use cfg_valid/cfg_ready with cfg_index and
//   cfg_data; cfg_ready is always high. Write only while no pixel is in
//   flight. Indexes beyond the register list are ignored.
//   Reset (arst_n low) restores the register reset values and drops every
//   pixel in flight; no result strobes until new pixels enter.
module phase_shift_ratio_decode #(
	parameter int SAMPLE_BITS   = psr_pkg::SAMPLE_BITS_DEF,
	parameter int FRACTION_BITS = psr_pkg::FRACTION_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  psr_pkg::pixel_t                pixel,
	output psr_pkg::result_t               result,
	output logic                           done,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [psr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [psr_pkg::GAIN_W-1:0]     cfg_data
);

	logic                     accept;
	logic                     sort_vld;
	logic [SAMPLE_BITS-1:0]   sort_num, sort_den;
	psr_pkg::side_t           sort_side;
	logic                     div_vld;
	logic [FRACTION_BITS-1:0] div_quo;
	psr_pkg::side_t           div_side;
	psr_pkg::cfg_t            cfg_q;

	// The pipeline never backs up, so the input is always open.
	assign busy      = 1'b0;
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	// Configuration registers; hold their value unless a write hits them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_gain <= psr_pkg::GAIN_RESET;
			cfg_q.mask_low   <= psr_pkg::MASK_LOW_RESET;
			cfg_q.mask_high  <= psr_pkg::MASK_HIGH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				psr_pkg::CFG_PHASE_GAIN: cfg_q.phase_gain <= cfg_data;
				psr_pkg::CFG_MASK_LOW:   cfg_q.mask_low   <= cfg_data[psr_pkg::MASK_W-1:0];
				psr_pkg::CFG_MASK_HIGH:  cfg_q.mask_high  <= cfg_data[psr_pkg::MASK_W-1:0];
				default: begin
					// Drop writes to unmapped indexes.
				end
			endcase
		end
	end

	// Order the samples and choose the region's numerator and denominator.
	psr_sort #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_sort (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (accept),
		.pixel   (pixel),
		.vld_s1  (sort_vld),
		.num_s1  (sort_num),
		.den_s1  (sort_den),
		.side_s1 (sort_side)
	);

	// Advance the fraction one quotient bit per stage.
	psr_div #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld      (sort_vld),
		.num      (sort_num),
		.den      (sort_den),
		.side     (sort_side),
		.vld_out  (div_vld),
		.quo      (div_quo),
		.side_out (div_side)
	);

	// Form the ratio, scale by the gain, saturate and apply the shading mask.
	psr_scale #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (div_vld),
		.quo    (div_quo),
		.side   (div_side),
		.cfg    (cfg_q),
		.result (result),
		.done   (done)
	);

endmodule

// ===== src/psr_sort.sv =====
// Front stage: order the three samples, pick numerator, denominator and region.
module psr_sort #(
	parameter int SAMPLE_BITS = psr_pkg::SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   vld,
	input  psr_pkg::pixel_t        pixel,
	output logic                   vld_s1,
	output logic [SAMPLE_BITS-1:0] num_s1,
	output logic [SAMPLE_BITS-1:0] den_s1,
	output psr_pkg::side_t         side_s1
);

	logic [SAMPLE_BITS-1:0] s0, s1, s2;
	logic                   gt01, gt12, gt02;
	logic [SAMPLE_BITS-1:0] num_c, den_c, bright_c;
	psr_pkg::side_t         side_c;

	assign s0 = pixel.sample_a[SAMPLE_BITS-1:0];
	assign s1 = pixel.sample_b[SAMPLE_BITS-1:0];
	assign s2 = pixel.sample_c[SAMPLE_BITS-1:0];

	assign gt01 = s0 > s1;
	assign gt12 = s1 > s2;
	assign gt02 = s0 > s2;

	always_comb begin
		side_c = '0;
		if (gt01) begin
			if (gt12) begin
				num_c = s1 - s2;
				den_c = s0 - s2;
				side_c.base = psr_pkg::BASE_0;
				side_c.subtract = 1'b0;
			end else if (gt02) begin
				num_c = s2 - s1;
				den_c = s0 - s1;
				side_c.base = psr_pkg::BASE_6;
				side_c.subtract = 1'b1;
			end else begin
				num_c = s0 - s1;
				den_c = s2 - s1;
				side_c.base = psr_pkg::BASE_4;
				side_c.subtract = 1'b0;
			end
		end else begin
			if (gt02) begin
				num_c = s0 - s2;
				den_c = s1 - s2;
				side_c.base = psr_pkg::BASE_2;
				side_c.subtract = 1'b1;
			end else if (gt12) begin
				num_c = s2 - s0;
				den_c = s1 - s0;
				side_c.base = psr_pkg::BASE_2;
				side_c.subtract = 1'b0;
			end else begin
				num_c = s1 - s0;
				den_c = s2 - s0;
				side_c.base = psr_pkg::BASE_4;
				side_c.subtract = 1'b1;
			end
		end
		bright_c = gt01 ? s0 : s1;
		if (s2 > bright_c) begin
			bright_c = s2;
		end
		side_c.flat = (den_c == '0);
		// A tie of the middle and the top sample gives a fraction of exactly one.
		side_c.whole = (num_c == den_c) && (den_c != '0);
		side_c.bright = psr_pkg::SAMPLE_W'(bright_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		num_s1  <= num_c;
		den_s1  <= den_c;
		side_s1 <= side_c;
	end

endmodule

// ===== src/psr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, side data carried along.
module psr_div #(
	parameter int SAMPLE_BITS   = psr_pkg::SAMPLE_BITS_DEF,
	parameter int FRACTION_BITS = psr_pkg::FRACTION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     vld,
	input  logic [SAMPLE_BITS-1:0]   num,
	input  logic [SAMPLE_BITS-1:0]   den,
	input  psr_pkg::side_t           side,
	output logic                     vld_out,
	output logic [FRACTION_BITS-1:0] quo,
	output psr_pkg::side_t           side_out
);

	logic                     vld_s  [1:FRACTION_BITS];
	logic [SAMPLE_BITS-1:0]   rem_s  [1:FRACTION_BITS];
	logic [SAMPLE_BITS-1:0]   den_s  [1:FRACTION_BITS];
	logic [FRACTION_BITS-1:0] quo_s  [1:FRACTION_BITS];
	psr_pkg::side_t           side_s [1:FRACTION_BITS];

	for (genvar k = 0; k < FRACTION_BITS; k++) begin : g_stage
		logic                     vld_c;
		logic [SAMPLE_BITS-1:0]   rem_c;
		logic [SAMPLE_BITS-1:0]   den_c;
		logic [FRACTION_BITS-1:0] quo_c;
		psr_pkg::side_t           side_c;
		logic [SAMPLE_BITS:0]     trial;
		logic                     ge;

		if (k == 0) begin : g_first
			assign vld_c  = vld;
			assign rem_c  = num;
			assign den_c  = den;
			assign quo_c  = '0;
			assign side_c = side;
		end else begin : g_next
			assign vld_c  = vld_s[k];
			assign rem_c  = rem_s[k];
			assign den_c  = den_s[k];
			assign quo_c  = quo_s[k];
			assign side_c = side_s[k];
		end

		// Remainder never exceeds the divisor, so the shifted trial needs one extra bit.
		assign trial = {rem_c, 1'b0};
		assign ge    = trial >= {1'b0, den_c};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_c;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? SAMPLE_BITS'(trial - {1'b0, den_c}) : trial[SAMPLE_BITS-1:0];
			den_s[k+1]  <= den_c;
			quo_s[k+1]  <= {quo_c[FRACTION_BITS-2:0], ge};
			side_s[k+1] <= side_c;
		end
	end

	assign vld_out  = vld_s[FRACTION_BITS];
	assign quo      = quo_s[FRACTION_BITS];
	assign side_out = side_s[FRACTION_BITS];

endmodule

// ===== src/psr_scale.sv =====
// Back stages: form the ratio, apply the gain, saturate and build the mask.
`include "phase_shift_ratio_decode_macros.svh"

module psr_scale #(
	parameter int FRACTION_BITS = psr_pkg::FRACTION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     vld,
	input  logic [FRACTION_BITS-1:0] quo,
	input  psr_pkg::side_t           side,
	input  psr_pkg::cfg_t            cfg,
	output psr_pkg::result_t         result,
	output logic                     done
);

	localparam int RATIO_W = FRACTION_BITS + 3;
	localparam int PROD_W  = RATIO_W + psr_pkg::GAIN_W;
	localparam int SHIFT   = FRACTION_BITS + 4;
	localparam logic [RATIO_W-1:0] RATIO_ONE  = RATIO_W'(1) << FRACTION_BITS;
	localparam logic [RATIO_W-1:0] RATIO_MAX  = RATIO_W'(6) << FRACTION_BITS;
	localparam logic [RATIO_W-1:0] RATIO_FLAT = RATIO_W'(4) << FRACTION_BITS;

	logic [RATIO_W-1:0]        base_c, frac_c, ratio_c;
	logic                      vld_s1, vld_s2;
	logic [RATIO_W-1:0]        ratio_s1;
	logic [PROD_W-1:0]         prod_s2;
	psr_pkg::side_t            side_s1, side_s2;
	logic                      sat_c;
	logic [psr_pkg::PHASE_W-1:0] phase_c;
	psr_pkg::result_t          result_q;
	logic                      done_q;

	// Flat pixels drop the quotient, which is meaningless for a zero divisor.
	// A fraction of exactly one does not fit the quotient and comes from its flag.
	assign frac_c  = side.flat ? '0 : (side.whole ? RATIO_ONE : RATIO_W'(quo));
	assign base_c  = RATIO_W'({side.base, 1'b0}) << FRACTION_BITS;
	assign ratio_c = side.subtract ? (base_c - frac_c) : (base_c + frac_c);

	assign sat_c   = |prod_s2[PROD_W-1:SHIFT+psr_pkg::PHASE_W];
	assign phase_c = sat_c ? '1 : prod_s2[SHIFT+psr_pkg::PHASE_W-1:SHIFT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			done_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		ratio_s1 <= ratio_c;
		side_s1  <= side;
		prod_s2  <= PROD_W'(ratio_s1) * PROD_W'(cfg.phase_gain);
		side_s2  <= side_s1;
		result_q.phase_value <= phase_c;
		result_q.brightness  <= side_s2.bright;
		result_q.pixel_valid <= (side_s2.bright > cfg.mask_low) &&
			(side_s2.bright < cfg.mask_high);
		result_q.flat_pixel  <= side_s2.flat;
	end

	assign result = result_q;
	assign done   = done_q;

	`PSR_ASSERT_SAME(a_ratio_range, clk, arst_n, vld_s1, ratio_s1 <= RATIO_MAX, "ratio above six")
	`PSR_ASSERT_SAME(a_flat_ratio, clk, arst_n, vld_s1 && side_s1.flat, ratio_s1 == RATIO_FLAT, "flat")
	`PSR_ASSERT_NEXT(a_done_follows, clk, arst_n, vld_s2, done, "result strobe missing")
	`PSR_ASSERT_SAME(a_mask_order, clk, arst_n, done && result.pixel_valid, cfg.mask_low < cfg.mask_high, "mask")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the phase shift ratio decoder: a directed table, then random pixels.
module tb;

	localparam int FRAC_BITS = psr_pkg::FRACTION_BITS_DEF;
	// Sort stage, one divider stage per quotient bit, then ratio, multiply and mask stages.
	localparam int PIPE_LATENCY = psr_pkg::FRACTION_BITS_DEF + 4;
	localparam int NUM_PHASES = 8;
	localparam int PIXELS_PER_PHASE = 165;
	// Longest quiet stretch of a good run is the drain plus the settle wait, well below this.
	localparam int QUIET_LIMIT = 2000;
	// The index field has one code with no register behind it.
	localparam logic [psr_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
	localparam logic [psr_pkg::PHASE_W-1:0] PHASE_MAX = '1;

	// Equal samples give a ratio of exactly 4.0, so at the reset gain the phase is the
	// gain shifted right by two (4 * 2^16 * gain >> 20).
	localparam logic [psr_pkg::PHASE_W-1:0] FLAT_PHASE = 28'd42722829;
	localparam psr_pkg::result_t NO_RESULT = '0;

	typedef struct packed {
		psr_pkg::pixel_t  px;
		logic             typed;
		psr_pkg::result_t want;
	} dir_row_t;

	localparam int NUM_DIRECTED = 22;
	// Rows with typed set carry their expected result; the rest go through the predictor.
	// All directed rows run at the reset register values.
	localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
		// Flat pixels at the sample extremes and at both sides of each threshold.
		'{'{16'd0, 16'd0, 16'd0}, 1'b1, '{FLAT_PHASE, 16'd0, 1'b0, 1'b1}},
		'{'{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, '{FLAT_PHASE, 16'hFFFF, 1'b0, 1'b1}},
		'{'{16'd15, 16'd15, 16'd15}, 1'b1, '{FLAT_PHASE, 16'd15, 1'b0, 1'b1}},
		'{'{16'd16, 16'd16, 16'd16}, 1'b1, '{FLAT_PHASE, 16'd16, 1'b1, 1'b1}},
		'{'{16'd100, 16'd100, 16'd100}, 1'b1, '{FLAT_PHASE, 16'd100, 1'b1, 1'b1}},
		'{'{16'd253, 16'd253, 16'd253}, 1'b1, '{FLAT_PHASE, 16'd253, 1'b1, 1'b1}},
		'{'{16'd254, 16'd254, 16'd254}, 1'b1, '{FLAT_PHASE, 16'd254, 1'b0, 1'b1}},
		// One pixel in each of the six sort regions.
		'{'{16'd3, 16'd2, 16'd1}, 1'b0, NO_RESULT},
		'{'{16'd3, 16'd1, 16'd2}, 1'b0, NO_RESULT},
		'{'{16'd2, 16'd1, 16'd3}, 1'b0, NO_RESULT},
		'{'{16'd2, 16'd3, 16'd1}, 1'b0, NO_RESULT},
		'{'{16'd1, 16'd3, 16'd2}, 1'b0, NO_RESULT},
		'{'{16'd1, 16'd2, 16'd3}, 1'b0, NO_RESULT},
		// Extremes: one or two samples at full scale, pairs tied, fractions near 0 and 1.
		'{'{16'hFFFF, 16'd0, 16'd0}, 1'b0, NO_RESULT},
		'{'{16'd0, 16'hFFFF, 16'd0}, 1'b0, NO_RESULT},
		'{'{16'd0, 16'd0, 16'hFFFF}, 1'b0, NO_RESULT},
		'{'{16'hFFFF, 16'hFFFF, 16'd0}, 1'b0, NO_RESULT},
		'{'{16'hFFFF, 16'd0, 16'hFFFF}, 1'b0, NO_RESULT},
		'{'{16'd0, 16'hFFFF, 16'hFFFF}, 1'b0, NO_RESULT},
		'{'{16'hFFFF, 16'hFFFE, 16'd0}, 1'b0, NO_RESULT},
		'{'{16'hFFFF, 16'd1, 16'd0}, 1'b0, NO_RESULT},
		'{'{16'hAAAA, 16'h5555, 16'd0}, 1'b0, NO_RESULT}
	};

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	psr_pkg::pixel_t               pixel = '0;
	logic                          cfg_valid = 1'b0;
	logic [psr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [psr_pkg::GAIN_W-1:0]    cfg_data = '0;
	logic                          busy;
	logic                          done;
	logic                          cfg_ready;
	psr_pkg::result_t              result;

	// Local copy of the register file, updated at each write transaction.
	logic [psr_pkg::GAIN_W-1:0] gain_reg = psr_pkg::GAIN_RESET;
	logic [psr_pkg::MASK_W-1:0] mask_low_reg = psr_pkg::MASK_LOW_RESET;
	logic [psr_pkg::MASK_W-1:0] mask_high_reg = psr_pkg::MASK_HIGH_RESET;

	// Decoded results still owed by the pipeline, oldest first.
	psr_pkg::result_t pending_results [$];
	int               error_count = 0;
	int               quiet_cycles = 0;

	phase_shift_ratio_decode dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.pixel     (pixel),
		.result    (result),
		.done      (done),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Decode one pixel the way the block should: pick the sort region, form the ratio
	// as base plus or minus (mid - low) / (high - low), scale by the gain, saturate; set brightness and flags.
	function automatic psr_pkg::result_t decode_pixel(input psr_pkg::pixel_t p);
		logic [63:0]                  s0, s1, s2, num, den, frac, ratio, scaled;
		logic                         subtract;
		psr_pkg::base_t               base;
		logic [psr_pkg::SAMPLE_W-1:0] bright;
		psr_pkg::result_t             r;
		s0 = 64'(p.sample_a);
		s1 = 64'(p.sample_b);
		s2 = 64'(p.sample_c);
		if (s0 > s1) begin
			if (s1 > s2) begin
				base = psr_pkg::BASE_0; subtract = 1'b0; num = s1 - s2; den = s0 - s2;
			end else if (s0 > s2) begin
				base = psr_pkg::BASE_6; subtract = 1'b1; num = s2 - s1; den = s0 - s1;
			end else begin
				base = psr_pkg::BASE_4; subtract = 1'b0; num = s0 - s1; den = s2 - s1;
			end
		end else begin
			if (s0 > s2) begin
				base = psr_pkg::BASE_2; subtract = 1'b1; num = s0 - s2; den = s1 - s2;
			end else if (s1 > s2) begin
				base = psr_pkg::BASE_2; subtract = 1'b0; num = s2 - s0; den = s1 - s0;
			end else begin
				base = psr_pkg::BASE_4; subtract = 1'b1; num = s1 - s0; den = s2 - s0;
			end
		end
		// A zero denominator only happens on a flat pixel: force the fraction to zero.
		frac = (den == 64'd0) ? 64'd0 : (num << FRAC_BITS) / den;
		ratio = (64'(base) * 64'd2) << FRAC_BITS;
		ratio = subtract ? ratio - frac : ratio + frac;
		scaled = (ratio * 64'(gain_reg)) >> (FRAC_BITS + 4);
		bright = (p.sample_a > p.sample_b) ? p.sample_a : p.sample_b;
		if (p.sample_c > bright)
			bright = p.sample_c;
		r.phase_value = (scaled > 64'(PHASE_MAX)) ? PHASE_MAX : scaled[psr_pkg::PHASE_W-1:0];
		r.brightness = bright;
		r.pixel_valid = (bright > mask_low_reg) && (bright < mask_high_reg);
		r.flat_pixel = (den == 64'd0);
		return r;
	endfunction

	// Random pixel: full-range samples in four draws of ten, else ties, flat pixels, rail
	// samples, near-equal samples, small samples or brightness around the current thresholds.
	function automatic psr_pkg::pixel_t random_pixel();
		logic [psr_pkg::SAMPLE_W-1:0] v [3];
		logic [psr_pkg::SAMPLE_W-1:0] edge_val;
		int                           k;
		int                           j;
		psr_pkg::pixel_t              p;
		for (j = 0; j < 3; j++)
			v[j] = 16'($urandom);
		case ($urandom_range(0, 9))
			4: begin
				v[1] = v[0];
				v[2] = v[0];
			end
			5: begin
				k = $urandom_range(0, 2);
				v[k] = v[(k + 1) % 3];
			end
			6: begin
				edge_val = ($urandom_range(0, 1) ? mask_low_reg : mask_high_reg)
					+ 16'($urandom_range(0, 4)) - 16'd2;
				k = $urandom_range(0, 2);
				for (j = 0; j < 3; j++)
					v[j] = (j == k) ? edge_val : 16'($urandom_range(0, int'(edge_val)));
			end
			7: begin
				for (j = 0; j < 3; j++)
					v[j] = $urandom_range(0, 1) ? 16'($urandom_range(0, 1))
						: 16'hFFFF - 16'($urandom_range(0, 1));
			end
			8: begin
				v[1] = v[0] + 16'($urandom_range(0, 2));
				v[2] = v[0] + 16'($urandom_range(0, 2));
			end
			9: begin
				for (j = 0; j < 3; j++)
					v[j] = 16'($urandom_range(0, 15));
			end
			default: ;
		endcase
		p.sample_a = v[0];
		p.sample_b = v[1];
		p.sample_c = v[2];
		return p;
	endfunction

	// Present one pixel and hold start until the transaction is taken, then log what
	// the pipeline owes for it. Start stays high so back-to-back pixels need no gap.
	task automatic send_pixel(input psr_pkg::pixel_t p, input logic typed,
		input psr_pkg::result_t want);
		psr_pkg::result_t owed;
		start <= 1'b1;
		pixel <= p;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		owed = typed ? want : decode_pixel(p);
		pending_results = {pending_results, owed};
	endtask

	task automatic hold_off(input int cycles);
		start <= 1'b0;
		repeat (cycles)
			@(posedge clk);
	endtask

	// Drop start and let the pipeline empty before the registers are touched.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY)
			@(posedge clk);
	endtask

	// One write transaction; valid is left high so writes can follow back to back.
	task automatic write_reg(input logic [psr_pkg::CFG_IDX_W-1:0] idx,
		input logic [psr_pkg::GAIN_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			psr_pkg::CFG_PHASE_GAIN: gain_reg = data;
			psr_pkg::CFG_MASK_LOW:   mask_low_reg = data[psr_pkg::MASK_W-1:0];
			psr_pkg::CFG_MASK_HIGH:  mask_high_reg = data[psr_pkg::MASK_W-1:0];
			default: ;
		endcase
	endtask

	// Register settings per phase: saturating gain with a wide-open window, zero gain
	// with a crossed window, an empty window plus a write to the unmapped index, the
	// reset gain, then random settings. Upper data bits of the mask writes are noise.
	task automatic configure(input int stage);
		logic [psr_pkg::GAIN_W-1:0] gain;
		logic [psr_pkg::MASK_W-1:0] low;
		logic [psr_pkg::MASK_W-1:0] high;
		gain = $urandom;
		low = 16'($urandom_range(0, 400));
		high = 16'($urandom_range(0, 600));
		case (stage)
			1: begin
				gain = '1; low = '0; high = '1;
			end
			2: begin
				gain = '0; low = '1; high = '0;
			end
			3: high = low;
			4: begin
				gain = psr_pkg::GAIN_RESET; low = '0; high = 16'($urandom_range(1000, 65535));
			end
			default: ;
		endcase
		write_reg(psr_pkg::CFG_PHASE_GAIN, gain);
		write_reg(psr_pkg::CFG_MASK_LOW, {16'($urandom), low});
		write_reg(psr_pkg::CFG_MASK_HIGH, {16'($urandom), high});
		if (stage == 3)
			write_reg(CFG_UNMAPPED, $urandom);
		cfg_valid <= 1'b0;
	endtask

	// Compare each strobed result with the oldest owed one, field by field.
	always @(posedge clk) begin
		psr_pkg::result_t want;
		if (done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, result);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (result.phase_value !== want.phase_value) begin
					$display("%0t: phase_value expected %0d actual %0d",
						$time, want.phase_value, result.phase_value);
					error_count++;
				end
				if (result.brightness !== want.brightness) begin
					$display("%0t: brightness expected %0d actual %0d",
						$time, want.brightness, result.brightness);
					error_count++;
				end
				if (result.pixel_valid !== want.pixel_valid) begin
					$display("%0t: pixel_valid expected %b actual %b",
						$time, want.pixel_valid, result.pixel_valid);
					error_count++;
				end
				if (result.flat_pixel !== want.flat_pixel) begin
					$display("%0t: flat_pixel expected %b actual %b",
						$time, want.flat_pixel, result.flat_pixel);
					error_count++;
				end
			end
		end
	end

	// Watchdog: count cycles with no transaction on any channel.
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int stage;
		int n;
		int row;
		int idle_pct;
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table at the reset register values, with some gaps.
		for (row = 0; row < NUM_DIRECTED; row++) begin
			if ($urandom_range(0, 99) < 20)
				hold_off($urandom_range(1, 15));
			send_pixel(DIRECTED[row].px, DIRECTED[row].typed, DIRECTED[row].want);
		end

		// Random phases, each under its own register setting; the last has no gaps.
		for (stage = 0; stage < NUM_PHASES; stage++) begin
			if (stage != 0) begin
				drain();
				configure(stage);
			end
			idle_pct = (stage == NUM_PHASES - 1) ? 0 : $urandom_range(0, 30);
			for (n = 0; n < PIXELS_PER_PHASE; n++) begin
				if ($urandom_range(0, 99) < idle_pct)
					hold_off($urandom_range(1, 15));
				send_pixel(random_pixel(), 1'b0, NO_RESULT);
			end
		end

		drain();
		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/psr_pkg.sv
src/psr_sort.sv
src/psr_div.sv
src/psr_scale.sv
src/phase_shift_ratio_decode.sv
tb/tb.sv
